// ===== rtl/core/ust_pkg.sv =====
// ----------------------------------------------------------------------------
// ust_pkg
// Request codes and controller state encoding for the unordered set table.
// ----------------------------------------------------------------------------
package ust_pkg;

    localparam logic [1:0] MODE_QUERY  = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned CountWidth = 5;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_REM_RD = 5'b00100,
        ST_REM_WR = 5'b01000,
        ST_DONE   = 5'b10000
    } ust_state_t;

endpackage

// ===== rtl/core/ust_ram.sv =====
// ----------------------------------------------------------------------------
// ust_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ust_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/unordered_set_table_unit.sv =====
// ----------------------------------------------------------------------------
// unordered_set_table_unit
// Set of distinct 32-bit values held in a RAM plus an element count.
//
// Input channel (in_valid/in_ready): mode and value. Mode 0 queries
// membership, 1 adds the value, 2 removes it; mode 3 is ignored.
// Output channel (out_valid/out_ready): success, full_res and the count
// after the request, one result per item.
// Entries are scanned in order through the single RAM read port, one read
// per cycle, until a hit or the end of the set ends the scan. A remove that
// hits then swaps the last entry into the hole through ST_REM_RD and
// ST_REM_WR before the result is loaded.
// One item is worked on at a time. The next item can be accepted in the cycle
// after the result is loaded, so no item is taken before the last one is
// through. A finished result sits in an output register, so the next item is
// accepted while it waits; a stalled receiver holds that next item at its end
// until the register frees.
// Reset empties the set at once; the RAM contents are not cleared and are
// only read below the element count.
// ----------------------------------------------------------------------------
module unordered_set_table_unit #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           mode,
    input  logic signed [ust_pkg::ValueWidth-1:0] value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 success,
    output logic                                 full_res,
    output logic [ust_pkg::CountWidth-1:0]       count
);

    import ust_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    ust_state_t             state_reg, state_next;
    logic [1:0]             mode_reg, mode_next;
    logic [ValueWidth-1:0]  value_reg, value_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          issue_reg, issue_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]          slot_reg, slot_next;
    logic                   ok_reg, ok_next;
    logic                   full_reg, full_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   success_reg, success_next;
    logic                   full_res_reg, full_res_next;
    logic [CountWidth-1:0]  count_out_reg, count_out_next;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [ValueWidth-1:0]  wr_data;
    logic [AW-1:0]          rd_addr;
    logic [ValueWidth-1:0]  rd_data;

    logic [CW-1:0]          last_idx;
    logic                   hit;
    logic                   scan_end;
    logic                   out_free;
    logic [CW+CountWidth-1:0] count_wide;

    ust_ram #(
        .WIDTH (ValueWidth),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign last_idx   = count_reg - {{(CW-1){1'b0}}, 1'b1};
    assign hit        = cmp_vld_reg && (rd_data == value_reg);
    assign scan_end   = (issue_reg >= count_reg) && !cmp_vld_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE);
    assign count_wide = {{CountWidth{1'b0}}, count_reg};
    assign rd_addr    = (state_reg == ST_REM_RD) ? last_idx[AW-1:0] : issue_reg[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        slot_next      = slot_reg;
        ok_next        = ok_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && !out_ready;
        success_next   = success_reg;
        full_res_next  = full_res_reg;
        count_out_next = count_out_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = value_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    value_next = value;
                    issue_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit || scan_end)
                begin
                    slot_next  = cmp_idx_reg;
                    ok_next    = 1'b0;
                    full_next  = 1'b0;
                    state_next = ST_DONE;
                    case (mode_reg)
                        MODE_QUERY:
                        begin
                            ok_next = hit;
                        end
                        MODE_ADD:
                        begin
                            if (!hit)
                            begin
                                if (count_reg == CW'(CAPACITY))
                                begin
                                    full_next = 1'b1;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    wr_addr    = count_reg[AW-1:0];
                                    wr_data    = value_reg;
                                    count_next = count_reg + {{(CW-1){1'b0}}, 1'b1};
                                    ok_next    = 1'b1;
                                end
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (hit)
                            begin
                                state_next = ST_REM_RD;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
                else if (issue_reg < count_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[AW-1:0];
                    issue_next   = issue_reg + {{(CW-1){1'b0}}, 1'b1};
                end
            end
            ST_REM_RD:
            begin
                state_next = ST_REM_WR;
            end
            ST_REM_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = slot_reg;
                wr_data    = rd_data;
                count_next = last_idx;
                ok_next    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    success_next   = ok_reg;
                    full_res_next  = full_reg;
                    count_out_next = count_wide[CountWidth-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        value_reg     <= value_next;
        issue_reg     <= issue_next;
        cmp_idx_reg   <= cmp_idx_next;
        slot_reg      <= slot_next;
        ok_reg        <= ok_next;
        full_reg      <= full_next;
        success_reg   <= success_next;
        full_res_reg  <= full_res_next;
        count_out_reg <= count_out_next;
    end

    assign out_valid = out_valid_reg;
    assign success   = success_reg;
    assign full_res  = full_res_reg;
    assign count     = count_out_reg;

endmodule

// ===== tb/sv/unordered_set_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// unordered_set_table_unit_tb
// Self-checking bench for the unordered set table. A short table of
// directed requests covers the value extremes, duplicate adds, a full store,
// removes that swap the last entry into the hole and the unused mode. Pool
// based random traffic follows, so that hits, duplicates and full-store
// refusals are frequent. A behavioral copy of the set predicts every reply.
// Both handshakes are throttled in two of the three phases; the third is free.
// ----------------------------------------------------------------------------
module unordered_set_table_unit_tb;

    import ust_pkg::*;

    localparam int unsigned Capacity      = 16;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam int unsigned PoolSize      = 24;
    localparam int unsigned ItemsPerPhase = 135;
    localparam int unsigned DrainCycles   = 60;
    localparam int unsigned ReportLimit   = 10;

    typedef struct packed {
        logic                  success;
        logic                  full_res;
        logic [CountWidth-1:0] count;
    } set_reply_t;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] value;
        set_reply_t  reply;
    } reply_entry_t;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] value;
        bit          typed;
        set_reply_t  reply;
    } stim_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [1:0]                   mode;
    logic signed [ValueWidth-1:0] value;
    logic                         out_valid;
    logic                         out_ready;
    logic                         success;
    logic                         full_res;
    logic [CountWidth-1:0]        count;

    logic [31:0]  held_values [Capacity];
    int unsigned  held_count;
    logic [31:0]  value_pool [PoolSize];
    reply_entry_t awaited_replies [$];
    stim_row_t    stim_table [$];
    int unsigned  fault_count;
    int unsigned  src_idle_pct;
    int unsigned  snk_stall_pct;

    unordered_set_table_unit #(
        .CAPACITY (Capacity)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .success   (success),
        .full_res  (full_res),
        .count     (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("unordered_set_table_unit_tb: errors");
        $finish;
    end

    function automatic set_reply_t apply_request(input logic [1:0] req_mode,
                                                 input logic [31:0] req_value);
        set_reply_t  r;
        int unsigned slot;
        r    = '0;
        slot = Capacity;
        for (int unsigned i = 0; i < held_count; i++)
        begin
            if (slot == Capacity && held_values[i] == req_value)
            begin
                slot = i;
            end
        end
        case (req_mode)
            MODE_QUERY:
            begin
                r.success = (slot < Capacity);
            end
            MODE_ADD:
            begin
                if (slot == Capacity)
                begin
                    if (held_count >= Capacity)
                    begin
                        r.full_res = 1'b1;
                    end
                    else
                    begin
                        held_values[held_count] = req_value;
                        held_count++;
                        r.success = 1'b1;
                    end
                end
            end
            MODE_REMOVE:
            begin
                if (slot < Capacity && held_count > 0)
                begin
                    held_values[slot] = held_values[held_count - 1];
                    held_count--;
                    r.success = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.count = held_count[CountWidth-1:0];
        return r;
    endfunction

    task automatic table_row(input logic [1:0] m, input logic [31:0] v, input bit typed,
                             input logic s, input logic f, input int unsigned c);
        stim_row_t row;
        row.mode  = m;
        row.value = v;
        row.typed = typed;
        row.reply = '{success: s, full_res: f, count: c[CountWidth-1:0]};
        stim_table.push_back(row);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [1:0] m, input logic [31:0] v,
                             input set_reply_t predicted);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        awaited_replies.push_back('{mode: m, value: v, reply: predicted});
        @(negedge clk);
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        @(negedge clk);
        while (awaited_replies.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic note_fault(input string what, input reply_entry_t want,
                              input set_reply_t got);
        if (fault_count < ReportLimit)
        begin
            $display("%s: mode %0d value %h expected s=%0b f=%0b c=%0d got s=%0b f=%0b c=%0d",
                     what, want.mode, want.value, want.reply.success, want.reply.full_res,
                     want.reply.count, got.success, got.full_res, got.count);
        end
        fault_count++;
    endtask

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        reply_entry_t want;
        set_reply_t   got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{success: success, full_res: full_res, count: count};
            if (awaited_replies.size() == 0)
            begin
                want = '{mode: 2'd0, value: 32'd0, reply: '0};
                note_fault("unexpected item", want, got);
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (want.reply.success !== got.success || want.reply.full_res !== got.full_res
                    || want.reply.count !== got.count)
                begin
                    note_fault("mismatch", want, got);
                end
            end
        end
    end

    initial
    begin
        logic [1:0]  m;
        logic [31:0] v;
        set_reply_t  predicted;
        int unsigned accepted;
        int unsigned pick;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_QUERY;
        value         = '0;
        out_ready     = 1'b0;
        fault_count   = 0;
        held_count    = 0;
        src_idle_pct  = 26;
        snk_stall_pct = 88;
        for (int unsigned i = 0; i < Capacity; i++)
        begin
            held_values[i] = '0;
        end
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int unsigned i = 4; i < PoolSize; i++)
        begin
            value_pool[i] = $urandom;
        end

        table_row(MODE_QUERY,  32'h0000_0000, 1, 0, 0, 0);
        table_row(MODE_REMOVE, 32'h0000_0005, 1, 0, 0, 0);
        table_row(MODE_UNUSED, 32'hFFFF_FFFF, 1, 0, 0, 0);
        table_row(MODE_ADD,    32'h8000_0000, 1, 1, 0, 1);
        table_row(MODE_ADD,    32'h7FFF_FFFF, 1, 1, 0, 2);
        table_row(MODE_ADD,    32'h8000_0000, 1, 0, 0, 2);
        table_row(MODE_QUERY,  32'h7FFF_FFFF, 1, 1, 0, 2);
        table_row(MODE_ADD,    32'h0000_0000, 1, 1, 0, 3);
        table_row(MODE_ADD,    32'hFFFF_FFFF, 1, 1, 0, 4);
        table_row(MODE_REMOVE, 32'h8000_0000, 1, 1, 0, 3);
        table_row(MODE_QUERY,  32'hFFFF_FFFF, 0, 0, 0, 0);
        for (int unsigned i = 0; i < 13; i++)
        begin
            table_row(MODE_ADD, 32'h5A5A_0000 + i, 0, 0, 0, 0);
        end
        table_row(MODE_ADD,    32'h1234_5678, 1, 0, 1, 16);
        table_row(MODE_ADD,    32'h7FFF_FFFF, 1, 0, 0, 16);
        table_row(MODE_UNUSED, 32'h0000_0000, 1, 0, 0, 16);
        table_row(MODE_REMOVE, 32'h0000_0000, 0, 0, 0, 0);
        table_row(MODE_QUERY,  32'h0000_0000, 0, 0, 0, 0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_table[i])
        begin
            predicted = apply_request(stim_table[i].mode, stim_table[i].value);
            if (stim_table[i].typed)
            begin
                predicted = stim_table[i].reply;
            end
            send_item(stim_table[i].mode, stim_table[i].value, predicted);
        end
        drain_replies();

        for (int unsigned phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 26;
                    snk_stall_pct = 88;
                end
                1:
                begin
                    src_idle_pct  = 88;
                    snk_stall_pct = 26;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
            endcase
            accepted = 0;
            while (accepted < ItemsPerPhase)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                begin
                    m = MODE_UNUSED;
                end
                else if (pick < 25)
                begin
                    m = MODE_QUERY;
                end
                else if (pick < 55)
                begin
                    m = MODE_REMOVE;
                end
                else
                begin
                    m = MODE_ADD;
                    accepted++;
                end
                if (m != MODE_UNUSED && m != MODE_ADD)
                begin
                    accepted++;
                end
                if ($urandom_range(0, 99) < 85)
                begin
                    v = value_pool[$urandom_range(0, PoolSize - 1)];
                end
                else
                begin
                    v = $urandom;
                end
                predicted = apply_request(m, v);
                send_item(m, v, predicted);
            end
            drain_replies();
        end

        repeat (DrainCycles) @(posedge clk);
        if (fault_count == 0 && awaited_replies.size() == 0)
        begin
            $display("unordered_set_table_unit_tb: clean");
        end
        else
        begin
            $display("unordered_set_table_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ust_pkg.sv
rtl/core/ust_ram.sv
rtl/core/unordered_set_table_unit.sv
tb/sv/unordered_set_table_unit_tb.sv
